>>> hw/rtl/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared constants, request and status codes, and controller-datapath types
// for the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

   localparam int STACK_DEPTH = 1024;
   localparam int MEM_BYTES   = 1024;
   localparam int WORD_W      = 32;
   localparam int SP_AW       = $clog2(STACK_DEPTH);
   localparam int MEM_AW      = $clog2(MEM_BYTES);
   localparam int CNT_W       = 11;
   localparam int MW_W        = 6;
   localparam int DCNT_W      = $clog2(WORD_W);

   localparam logic [3:0] REQ_PUSH   = 4'd0;
   localparam logic [3:0] REQ_POP    = 4'd1;
   localparam logic [3:0] REQ_DUP    = 4'd2;
   localparam logic [3:0] REQ_SWAP   = 4'd3;
   localparam logic [3:0] REQ_ISZERO = 4'd4;
   localparam logic [3:0] REQ_LT     = 4'd5;
   localparam logic [3:0] REQ_ADD    = 4'd6;
   localparam logic [3:0] REQ_MUL    = 4'd7;
   localparam logic [3:0] REQ_SUB    = 4'd8;
   localparam logic [3:0] REQ_SDIV   = 4'd9;
   localparam logic [3:0] REQ_MSTORE = 4'd10;
   localparam logic [3:0] REQ_MLOAD  = 4'd11;
   localparam logic [3:0] REQ_MSIZE  = 4'd12;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNDERFLOW = 3'd1;
   localparam logic [2:0] ST_OVERFLOW  = 3'd2;
   localparam logic [2:0] ST_BAD_INDEX = 3'd3;
   localparam logic [2:0] ST_BAD_ADDR  = 3'd4;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CLR,
      CMD_START,
      CMD_TAKE,
      CMD_LATCH_A,
      CMD_LATCH_B,
      CMD_RD_DUP,
      CMD_RD_TOP,
      CMD_RD_LOW,
      CMD_WR_TOP,
      CMD_WR_LOW,
      CMD_FLAG_IDX,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_MEM_RD,
      CMD_MEM_WR,
      CMD_ALU,
      CMD_PUT,
      CMD_SHOW_RD,
      CMD_SHOW_OUT,
      CMD_POP_OUT
   } cmd_type;

   typedef struct packed {
      logic [3:0] req_type;
      logic       dup_ok;
      logic       swap_ok;
      logic       div_done;
      logic       clr_done;
   } dp_status_type;

endpackage

>>> hw/rtl/smeu_dpath.sv
// ----------------------------------------------------------------------------
// smeu_dpath
// Datapath: stack RAM, byte memory, operand registers, ALU, iterative
// divider and result registers, driven by commands from the controller.
// ----------------------------------------------------------------------------
module smeu_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  smeu_pkg::cmd_type         cmd,
   input  logic [3:0]                req_type,
   input  logic signed [31:0]        req_push_value,
   input  logic [10:0]               req_slot_index,
   output smeu_pkg::dp_status_type   stat,
   output logic signed [31:0]        rsp_top_value,
   output logic [10:0]               rsp_stack_depth,
   output logic [2:0]                rsp_status
);

   logic [smeu_pkg::WORD_W-1:0] stack_mem [smeu_pkg::STACK_DEPTH];
   logic [7:0]                  byte_mem  [smeu_pkg::MEM_BYTES];

   logic [3:0]                  op_ff;
   logic [smeu_pkg::WORD_W-1:0] pv_ff;
   logic [smeu_pkg::CNT_W-1:0]  idx_ff;
   logic [smeu_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [smeu_pkg::WORD_W-1:0] a_ff, b_ff, res_ff, res_in, rd_ff;
   logic                        emp_ff;
   logic [7:0]                  mrd_ff;
   logic [2:0]                  status_ff;
   logic [smeu_pkg::MW_W-1:0]   mw_ff;
   logic [smeu_pkg::MEM_AW-1:0] clr_ff;
   logic [smeu_pkg::WORD_W-1:0] dq_ff, drem_ff, dm_ff;
   logic                        dneg_ff;
   logic [smeu_pkg::DCNT_W-1:0] dcnt_ff;
   logic [smeu_pkg::WORD_W-1:0] out_top_ff;
   logic [smeu_pkg::CNT_W-1:0]  out_depth_ff;
   logic [2:0]                  out_status_ff;

   logic [smeu_pkg::CNT_W-1:0]  cnt_m1, dup_addr, low_addr;
   logic                        empty, full, addr_ok;
   logic                        st_we, st_re;
   logic [smeu_pkg::SP_AW-1:0]  st_waddr, st_raddr;
   logic [smeu_pkg::WORD_W-1:0] st_wdata;
   logic                        mem_we;
   logic [smeu_pkg::MEM_AW-1:0] mem_waddr;
   logic [7:0]                  mem_wdata;
   logic [smeu_pkg::WORD_W-1:0] mag_a, mag_b, div_res;
   logic [smeu_pkg::WORD_W:0]   rem_sh, rem_diff;
   logic [smeu_pkg::MW_W-1:0]   grow_words;

   function automatic logic [2:0] first_fault(input logic [2:0] cur, input logic [2:0] code);
      first_fault = (cur == smeu_pkg::ST_OK) ? code : cur;
   endfunction

   assign cnt_m1   = cnt_ff - smeu_pkg::CNT_W'(1);
   assign dup_addr = cnt_ff - idx_ff;
   assign low_addr = cnt_m1 - idx_ff;
   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff >= smeu_pkg::CNT_W'(smeu_pkg::STACK_DEPTH));
   assign addr_ok  = (a_ff[smeu_pkg::WORD_W-1:smeu_pkg::MEM_AW] == '0);
   assign grow_words = smeu_pkg::MW_W'(a_ff[smeu_pkg::MEM_AW-1:5]) + smeu_pkg::MW_W'(1);

   assign stat.req_type = op_ff;
   assign stat.dup_ok   = (idx_ff != '0) && (idx_ff <= cnt_ff);
   assign stat.swap_ok  = (idx_ff != '0) && (idx_ff < cnt_ff);
   assign stat.div_done = (dcnt_ff == {smeu_pkg::DCNT_W{1'b1}});
   assign stat.clr_done = (clr_ff == {smeu_pkg::MEM_AW{1'b1}});

   // magnitudes and one restoring step
   assign mag_a    = a_ff[smeu_pkg::WORD_W-1] ? (~a_ff + 1'b1) : a_ff;
   assign mag_b    = b_ff[smeu_pkg::WORD_W-1] ? (~b_ff + 1'b1) : b_ff;
   assign rem_sh   = {drem_ff, dq_ff[smeu_pkg::WORD_W-1]};
   assign rem_diff = rem_sh - {1'b0, dm_ff};
   assign div_res  = (dm_ff == '0) ? '0 : (dneg_ff ? (~dq_ff + 1'b1) : dq_ff);

   always_comb begin
      res_in = a_ff;
      case (op_ff)
         smeu_pkg::REQ_PUSH:   res_in = pv_ff;
         smeu_pkg::REQ_ISZERO: res_in = smeu_pkg::WORD_W'(a_ff == '0);
         smeu_pkg::REQ_LT:     res_in = smeu_pkg::WORD_W'($signed(a_ff) < $signed(b_ff));
         smeu_pkg::REQ_ADD:    res_in = a_ff + b_ff;
         smeu_pkg::REQ_MUL:    res_in = a_ff * b_ff;
         smeu_pkg::REQ_SUB:    res_in = a_ff - b_ff;
         smeu_pkg::REQ_SDIV:   res_in = div_res;
         smeu_pkg::REQ_MLOAD:  res_in = addr_ok ? smeu_pkg::WORD_W'(mrd_ff) : '0;
         smeu_pkg::REQ_MSIZE:  res_in = smeu_pkg::WORD_W'({mw_ff, 5'b0});
         default:              res_in = a_ff;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd == smeu_pkg::CMD_TAKE && !empty) begin
         cnt_in = cnt_m1;
      end else if (cmd == smeu_pkg::CMD_PUT && !full) begin
         cnt_in = cnt_ff + smeu_pkg::CNT_W'(1);
      end
   end

   // stack ram port control
   always_comb begin
      st_we    = 1'b0;
      st_waddr = cnt_ff[smeu_pkg::SP_AW-1:0];
      st_wdata = res_ff;
      st_re    = 1'b0;
      st_raddr = cnt_m1[smeu_pkg::SP_AW-1:0];
      case (cmd) inside
         smeu_pkg::CMD_PUT: begin
            st_we = !full;
         end
         smeu_pkg::CMD_WR_TOP: begin
            st_we    = 1'b1;
            st_waddr = cnt_m1[smeu_pkg::SP_AW-1:0];
            st_wdata = b_ff;
         end
         smeu_pkg::CMD_WR_LOW: begin
            st_we    = 1'b1;
            st_waddr = low_addr[smeu_pkg::SP_AW-1:0];
            st_wdata = a_ff;
         end
         smeu_pkg::CMD_TAKE, smeu_pkg::CMD_RD_TOP, smeu_pkg::CMD_SHOW_RD: begin
            st_re = 1'b1;
         end
         smeu_pkg::CMD_RD_DUP: begin
            st_re    = 1'b1;
            st_raddr = dup_addr[smeu_pkg::SP_AW-1:0];
         end
         smeu_pkg::CMD_RD_LOW: begin
            st_re    = 1'b1;
            st_raddr = low_addr[smeu_pkg::SP_AW-1:0];
         end
         default: begin
            st_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         stack_mem[st_waddr] <= st_wdata;
      end
      if (st_re) begin
         rd_ff <= stack_mem[st_raddr];
      end
   end

   assign mem_we    = (cmd == smeu_pkg::CMD_CLR) || (cmd == smeu_pkg::CMD_MEM_WR && addr_ok);
   assign mem_waddr = (cmd == smeu_pkg::CMD_CLR) ? clr_ff : a_ff[smeu_pkg::MEM_AW-1:0];
   assign mem_wdata = (cmd == smeu_pkg::CMD_CLR) ? 8'h00 : b_ff[7:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd == smeu_pkg::CMD_MEM_RD) begin
         mrd_ff <= byte_mem[a_ff[smeu_pkg::MEM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         mw_ff     <= smeu_pkg::MW_W'(4);
         status_ff <= smeu_pkg::ST_OK;
         clr_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         case (cmd)
            smeu_pkg::CMD_CLR: begin
               clr_ff <= clr_ff + 1'b1;
            end
            smeu_pkg::CMD_START: begin
               status_ff <= smeu_pkg::ST_OK;
            end
            smeu_pkg::CMD_TAKE: begin
               if (empty) begin
                  status_ff <= first_fault(status_ff, smeu_pkg::ST_UNDERFLOW);
               end
            end
            smeu_pkg::CMD_PUT: begin
               if (full) begin
                  status_ff <= first_fault(status_ff, smeu_pkg::ST_OVERFLOW);
               end
            end
            smeu_pkg::CMD_FLAG_IDX: begin
               status_ff <= first_fault(status_ff, smeu_pkg::ST_BAD_INDEX);
            end
            smeu_pkg::CMD_MEM_WR: begin
               if (!addr_ok) begin
                  status_ff <= first_fault(status_ff, smeu_pkg::ST_BAD_ADDR);
               end else if (grow_words > mw_ff) begin
                  mw_ff <= grow_words;
               end
            end
            smeu_pkg::CMD_ALU: begin
               if (op_ff == smeu_pkg::REQ_MLOAD && !addr_ok) begin
                  status_ff <= first_fault(status_ff, smeu_pkg::ST_BAD_ADDR);
               end
            end
            default: begin
               clr_ff <= clr_ff;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd) inside
         smeu_pkg::CMD_START: begin
            op_ff  <= req_type;
            pv_ff  <= req_push_value;
            idx_ff <= req_slot_index;
         end
         smeu_pkg::CMD_TAKE: begin
            emp_ff <= empty;
         end
         smeu_pkg::CMD_RD_DUP, smeu_pkg::CMD_RD_TOP, smeu_pkg::CMD_RD_LOW: begin
            emp_ff <= 1'b0;
         end
         smeu_pkg::CMD_LATCH_A: begin
            a_ff <= emp_ff ? '0 : rd_ff;
         end
         smeu_pkg::CMD_LATCH_B: begin
            b_ff <= emp_ff ? '0 : rd_ff;
         end
         smeu_pkg::CMD_DIV_INIT: begin
            dq_ff   <= mag_a;
            dm_ff   <= mag_b;
            drem_ff <= '0;
            dneg_ff <= a_ff[smeu_pkg::WORD_W-1] ^ b_ff[smeu_pkg::WORD_W-1];
            dcnt_ff <= '0;
         end
         smeu_pkg::CMD_DIV_STEP: begin
            if (!rem_diff[smeu_pkg::WORD_W]) begin
               drem_ff <= rem_diff[smeu_pkg::WORD_W-1:0];
               dq_ff   <= {dq_ff[smeu_pkg::WORD_W-2:0], 1'b1};
            end else begin
               drem_ff <= rem_sh[smeu_pkg::WORD_W-1:0];
               dq_ff   <= {dq_ff[smeu_pkg::WORD_W-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         smeu_pkg::CMD_ALU: begin
            res_ff <= res_in;
         end
         smeu_pkg::CMD_SHOW_OUT: begin
            out_top_ff    <= empty ? '0 : rd_ff;
            out_depth_ff  <= cnt_ff;
            out_status_ff <= status_ff;
         end
         smeu_pkg::CMD_POP_OUT: begin
            out_top_ff    <= a_ff;
            out_depth_ff  <= cnt_ff;
            out_status_ff <= status_ff;
         end
         default: begin
            res_ff <= res_ff;
         end
      endcase
   end

   assign rsp_top_value   = out_top_ff;
   assign rsp_stack_depth = out_depth_ff;
   assign rsp_status      = out_status_ff;

endmodule

>>> hw/rtl/smeu_ctrl.sv
// ----------------------------------------------------------------------------
// smeu_ctrl
// Controller: sequences each instruction through the datapath and owns the
// request and response handshakes.
// ----------------------------------------------------------------------------
module smeu_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  smeu_pkg::dp_status_type   stat,
   output smeu_pkg::cmd_type         cmd
);

   typedef enum logic [22:0] {
      S_CLEAR    = 23'h000001,
      S_IDLE     = 23'h000002,
      S_DECODE   = 23'h000004,
      S_TAKE_A   = 23'h000008,
      S_GET_A    = 23'h000010,
      S_TAKE_B   = 23'h000020,
      S_GET_B    = 23'h000040,
      S_RD_DUP   = 23'h000080,
      S_GET_DUP  = 23'h000100,
      S_RD_TOP   = 23'h000200,
      S_GET_TOP  = 23'h000400,
      S_RD_LOW   = 23'h000800,
      S_GET_LOW  = 23'h001000,
      S_WR_TOP   = 23'h002000,
      S_WR_LOW   = 23'h004000,
      S_DIV_INIT = 23'h008000,
      S_DIV      = 23'h010000,
      S_MEM_RD   = 23'h020000,
      S_ALU      = 23'h040000,
      S_PUT      = 23'h080000,
      S_MEM_WR   = 23'h100000,
      S_SHOW_RD  = 23'h200000,
      S_OUT      = 23'h400000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      pop_ff, pop_in;
   logic      out_free, load;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign load      = (cmd == smeu_pkg::CMD_SHOW_OUT) || (cmd == smeu_pkg::CMD_POP_OUT);

   always_comb begin
      state_in = state_ff;
      pop_in   = pop_ff;
      cmd      = smeu_pkg::CMD_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd = smeu_pkg::CMD_CLR;
            if (stat.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd      = smeu_pkg::CMD_START;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            pop_in = 1'b0;
            case (stat.req_type) inside
               smeu_pkg::REQ_PUSH, smeu_pkg::REQ_MSIZE: begin
                  state_in = S_ALU;
               end
               smeu_pkg::REQ_DUP: begin
                  if (stat.dup_ok) begin
                     state_in = S_RD_DUP;
                  end else begin
                     cmd      = smeu_pkg::CMD_FLAG_IDX;
                     state_in = S_SHOW_RD;
                  end
               end
               smeu_pkg::REQ_SWAP: begin
                  if (stat.swap_ok) begin
                     state_in = S_RD_TOP;
                  end else begin
                     cmd      = smeu_pkg::CMD_FLAG_IDX;
                     state_in = S_SHOW_RD;
                  end
               end
               smeu_pkg::REQ_POP: begin
                  pop_in   = 1'b1;
                  state_in = S_TAKE_A;
               end
               smeu_pkg::REQ_ISZERO, smeu_pkg::REQ_LT, smeu_pkg::REQ_ADD,
               smeu_pkg::REQ_MUL, smeu_pkg::REQ_SUB, smeu_pkg::REQ_SDIV,
               smeu_pkg::REQ_MSTORE, smeu_pkg::REQ_MLOAD: begin
                  state_in = S_TAKE_A;
               end
               default: begin
                  state_in = S_SHOW_RD;
               end
            endcase
         end
         S_TAKE_A: begin
            cmd      = smeu_pkg::CMD_TAKE;
            state_in = S_GET_A;
         end
         S_GET_A: begin
            cmd = smeu_pkg::CMD_LATCH_A;
            case (stat.req_type)
               smeu_pkg::REQ_POP:    state_in = S_OUT;
               smeu_pkg::REQ_ISZERO: state_in = S_ALU;
               smeu_pkg::REQ_MLOAD:  state_in = S_MEM_RD;
               default:              state_in = S_TAKE_B;
            endcase
         end
         S_TAKE_B: begin
            cmd      = smeu_pkg::CMD_TAKE;
            state_in = S_GET_B;
         end
         S_GET_B: begin
            cmd = smeu_pkg::CMD_LATCH_B;
            case (stat.req_type)
               smeu_pkg::REQ_SDIV:   state_in = S_DIV_INIT;
               smeu_pkg::REQ_MSTORE: state_in = S_MEM_WR;
               default:              state_in = S_ALU;
            endcase
         end
         S_RD_DUP: begin
            cmd      = smeu_pkg::CMD_RD_DUP;
            state_in = S_GET_DUP;
         end
         S_GET_DUP: begin
            cmd      = smeu_pkg::CMD_LATCH_A;
            state_in = S_ALU;
         end
         S_RD_TOP: begin
            cmd      = smeu_pkg::CMD_RD_TOP;
            state_in = S_GET_TOP;
         end
         S_GET_TOP: begin
            cmd      = smeu_pkg::CMD_LATCH_A;
            state_in = S_RD_LOW;
         end
         S_RD_LOW: begin
            cmd      = smeu_pkg::CMD_RD_LOW;
            state_in = S_GET_LOW;
         end
         S_GET_LOW: begin
            cmd      = smeu_pkg::CMD_LATCH_B;
            state_in = S_WR_TOP;
         end
         S_WR_TOP: begin
            cmd      = smeu_pkg::CMD_WR_TOP;
            state_in = S_WR_LOW;
         end
         S_WR_LOW: begin
            cmd      = smeu_pkg::CMD_WR_LOW;
            state_in = S_SHOW_RD;
         end
         S_DIV_INIT: begin
            cmd      = smeu_pkg::CMD_DIV_INIT;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd = smeu_pkg::CMD_DIV_STEP;
            if (stat.div_done) begin
               state_in = S_ALU;
            end
         end
         S_MEM_RD: begin
            cmd      = smeu_pkg::CMD_MEM_RD;
            state_in = S_ALU;
         end
         S_ALU: begin
            cmd      = smeu_pkg::CMD_ALU;
            state_in = S_PUT;
         end
         S_PUT: begin
            cmd      = smeu_pkg::CMD_PUT;
            state_in = S_SHOW_RD;
         end
         S_MEM_WR: begin
            cmd      = smeu_pkg::CMD_MEM_WR;
            state_in = S_SHOW_RD;
         end
         S_SHOW_RD: begin
            cmd      = smeu_pkg::CMD_SHOW_RD;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd      = pop_ff ? smeu_pkg::CMD_POP_OUT : smeu_pkg::CMD_SHOW_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         pop_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pop_ff       <= pop_in;
      end
   end

endmodule

>>> hw/rtl/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack instruction per request beat on a 1024-entry signed
// 32-bit stack and a 1024-byte memory; one response beat per request.
// ----------------------------------------------------------------------------
// After reset the unit clears all 1024 bytes of the byte memory before
// req_ready first rises. It then works on one instruction at a time: the
// time from the request beat to the response beat is set by the stack RAM
// accesses (each pop and the final top-of-stack read cost a registered
// read), and for sdiv by the 32-step restoring divider. A finished
// response waits in an output register, so the next request is taken
// while it is still pending.
module stack_machine_execute_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_type,
   input  logic signed [31:0] req_push_value,
   input  logic [10:0]        req_slot_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_top_value,
   output logic [10:0]        rsp_stack_depth,
   output logic [2:0]         rsp_status
);

   smeu_pkg::cmd_type       cmd;
   smeu_pkg::dp_status_type stat;

   smeu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   smeu_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_type        (req_type),
      .req_push_value  (req_push_value),
      .req_slot_index  (req_slot_index),
      .stat            (stat),
      .rsp_top_value   (rsp_top_value),
      .rsp_stack_depth (rsp_stack_depth),
      .rsp_status      (rsp_status)
   );

endmodule
